[hdl/pbcc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types of the pulse battery charge controller.
package pbcc_pkg;

  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Hold-off length after a too-fast voltage step, in ticks.
  localparam logic [TIMER_W-1:0]  HOLDOFF_TICKS = 16'd333;
  // Consecutive end-voltage readings that finish the process.
  localparam logic [SAMPLE_W-1:0] END_COUNT     = 8'd3;
  // Duty offset before twice the user setting is added.
  localparam logic [SAMPLE_W-1:0] DUTY_BASE     = 8'd20;
  // The current window around the setting is adjust+8 .. adjust+10.
  localparam logic [SAMPLE_W:0]   CUR_LOW_OFS   = 9'd8;
  localparam logic [SAMPLE_W:0]   CUR_HIGH_OFS  = 9'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_MIN       = 3'd0,
    REG_ANGLE_MAX       = 3'd1,
    REG_BATT_PRESENT    = 3'd2,
    REG_CHARGE_START    = 3'd3,
    REG_CHARGE_END      = 3'd4,
    REG_DELTA_LIMIT     = 3'd5,
    REG_CHARGE_TICKS    = 3'd6,
    REG_DISCHARGE_TICKS = 3'd7
  } cfg_reg_t;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [TIMER_W-1:0]  timer_t;

endpackage

[hdl/pbcc_in_if.sv]
`timescale 1ns / 1ps
// Input channel of the charge controller: one control pass per item.
interface pbcc_in_if;
  import pbcc_pkg::*;

  logic    valid;
  logic    ready;
  logic    tick;
  sample_t voltage;
  sample_t current;
  sample_t adjust;
  logic    adjust_changed;

  modport source (output valid, output tick, output voltage, output current,
                  output adjust, output adjust_changed, input ready);
  modport sink   (input valid, input tick, input voltage, input current,
                  input adjust, input adjust_changed, output ready);
endinterface

[hdl/pbcc_out_if.sv]
`timescale 1ns / 1ps
// Result channel of the charge controller: angle, duty and phase flags.
interface pbcc_out_if;
  import pbcc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t fire_angle;
  sample_t pwm_duty;
  logic    charging;
  logic    discharging;
  logic    process_running;
  logic    fast_change_hold;

  modport source (output valid, output fire_angle, output pwm_duty, output charging,
                  output discharging, output process_running,
                  output fast_change_hold, input ready);
  modport sink   (input valid, input fire_angle, input pwm_duty, input charging,
                  input discharging, input process_running,
                  input fast_change_hold, output ready);
endinterface

[hdl/pulse_battery_charge_controller_unit.sv]
`timescale 1ns / 1ps
// Top level of the pulse battery charge controller.
//
// Each input item is one control pass: a tick flag, a voltage and current sample, the
// user setting and an adjust-changed flag. The block accepts one item per clock while
// the result side keeps taking items, and returns exactly one result item per input
// item. The item lands in an input register when it is accepted; the pass logic then
// updates the controller state and loads the result register when the item advances
// out of the input register. The result carries the state after the pass: thyristor
// angle, PWM duty and the charge, discharge, running and hold-off flags.
// Throughput is one item per clock as long as the result side keeps taking items; the
// input register and the result register let both sides stall independently.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and should only
// be changed while no item is in flight.
module pulse_battery_charge_controller_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  pbcc_in_if.sink                            in_ch,
  pbcc_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [pbcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pbcc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pbcc_pkg::*;

  // Configuration registers.
  sample_t angle_min_r, angle_max_r, batt_present_r, charge_start_r;
  sample_t charge_end_r, delta_limit_r;
  timer_t  charge_ticks_r, discharge_ticks_r;

  // Input register stage.
  logic    s1_valid_r;
  logic    s1_tick_r;
  sample_t s1_voltage_r, s1_current_r, s1_adjust_r;
  logic    s1_adj_chg_r;

  // Controller state.
  sample_t prev_voltage_r, prev_voltage_nxt;
  timer_t  phase_timer_r, phase_timer_nxt;
  sample_t angle_trim_r, angle_trim_nxt;
  sample_t end_hits_r, end_hits_nxt;
  logic    run_r, run_nxt;
  logic    first_conn_r, first_conn_nxt;
  logic    charge_r, charge_nxt;
  logic    discharge_r, discharge_nxt;
  logic    hold_r, hold_nxt;
  logic    upd_pend_r, upd_pend_nxt;
  sample_t angle_r, angle_nxt;
  sample_t duty_r, duty_nxt;

  // Result register.
  logic    out_valid_r;

  logic    advance;
  logic    s1_load;
  sample_t raw_angle;
  sample_t volt_diff;
  logic    fast_step;
  logic    start_proc;
  logic    chg_phase_done;
  logic    discharge_end;
  logic [SAMPLE_W:0] adj_wide;

  // The pass in the input register moves on when the result register is free
  // or is being emptied this cycle.
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign s1_load     = in_ch.valid && in_ch.ready;

  assign adj_wide = {1'b0, s1_adjust_r};

  // One control pass of the controller state.
  always_comb begin
    prev_voltage_nxt = prev_voltage_r;
    phase_timer_nxt  = phase_timer_r;
    angle_trim_nxt   = angle_trim_r;
    end_hits_nxt     = end_hits_r;
    run_nxt          = run_r;
    first_conn_nxt   = first_conn_r;
    charge_nxt       = charge_r;
    discharge_nxt    = discharge_r;
    hold_nxt         = hold_r;
    upd_pend_nxt     = upd_pend_r;
    angle_nxt        = angle_r;
    duty_nxt         = duty_r;
    raw_angle        = angle_min_r - s1_adjust_r - angle_trim_r;
    start_proc       = 1'b0;
    chg_phase_done   = 1'b0;
    discharge_end    = 1'b0;

    // The phase timer saturates instead of wrapping.
    if (s1_tick_r && (phase_timer_r != '1)) begin
      phase_timer_nxt = phase_timer_r + 1'b1;
    end

    // A pending update or a changed setting refreshes the duty and the clamped firing angle.
    if (upd_pend_r || s1_adj_chg_r) begin
      duty_nxt     = DUTY_BASE + {s1_adjust_r[SAMPLE_W-2:0], 1'b0};
      angle_nxt    = (raw_angle < angle_max_r) ? angle_max_r : raw_angle;
      upd_pend_nxt = 1'b0;
    end

    volt_diff = (s1_voltage_r > prev_voltage_r) ? (s1_voltage_r - prev_voltage_r)
                                                : (prev_voltage_r - s1_voltage_r);
    fast_step = volt_diff > delta_limit_r;
    if (fast_step) begin
      hold_nxt        = 1'b1;
      phase_timer_nxt = '0;
    end
    prev_voltage_nxt = s1_voltage_r;

    if (hold_nxt) begin
      // Hold-off: drop the process and wait out the hold-off time.
      if (run_r) begin
        run_nxt        = 1'b0;
        first_conn_nxt = 1'b0;
        charge_nxt     = 1'b0;
        discharge_nxt  = 1'b0;
        angle_trim_nxt = '0;
        upd_pend_nxt   = 1'b1;
      end
      if (phase_timer_nxt >= HOLDOFF_TICKS) begin
        hold_nxt = 1'b0;
      end
    end else if (s1_voltage_r > batt_present_r) begin
      // A new battery, or a charged one that has dropped below the charge-start level, starts charging.
      start_proc = !run_r && (!first_conn_r || (s1_voltage_r < charge_start_r));
      if (start_proc) begin
        first_conn_nxt  = 1'b1;
        run_nxt         = 1'b1;
        charge_nxt      = 1'b1;
        phase_timer_nxt = '0;
        end_hits_nxt    = '0;
      end
      chg_phase_done = charge_nxt && (phase_timer_nxt >= charge_ticks_r);
      if (chg_phase_done) begin
        // Trim the angle so that the current moves toward adjust+9.
        if ({1'b0, s1_current_r} <= adj_wide + CUR_LOW_OFS) begin
          angle_trim_nxt = angle_trim_r + 1'b1;
          upd_pend_nxt   = 1'b1;
        end
        if ({1'b0, s1_current_r} >= adj_wide + CUR_HIGH_OFS) begin
          angle_trim_nxt = angle_trim_r - 1'b1;
          upd_pend_nxt   = 1'b1;
        end
        phase_timer_nxt = '0;
        charge_nxt      = 1'b0;
        discharge_nxt   = 1'b1;
      end
      discharge_end = discharge_nxt && (phase_timer_nxt >= discharge_ticks_r);
      if (discharge_end) begin
        phase_timer_nxt = '0;
        discharge_nxt   = 1'b0;
        charge_nxt      = 1'b1;
      end
      if (chg_phase_done) begin
        // End of charge is judged only at charge-phase ends.
        if (s1_voltage_r >= charge_end_r) begin
          end_hits_nxt = end_hits_nxt + 1'b1;
          if (end_hits_nxt >= END_COUNT) begin
            end_hits_nxt  = '0;
            run_nxt       = 1'b0;
            charge_nxt    = 1'b0;
            discharge_nxt = 1'b0;
          end
        end else begin
          end_hits_nxt = '0;
        end
      end
    end else if (run_r || first_conn_r) begin
      // Battery removed.
      run_nxt        = 1'b0;
      first_conn_nxt = 1'b0;
      charge_nxt     = 1'b0;
      discharge_nxt  = 1'b0;
      angle_trim_nxt = '0;
      upd_pend_nxt   = 1'b1;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_min_r       <= 8'd200;
      angle_max_r       <= 8'd20;
      batt_present_r    <= 8'd50;
      charge_start_r    <= 8'd120;
      charge_end_r      <= 8'd150;
      delta_limit_r     <= 8'd10;
      charge_ticks_r    <= 16'd333;
      discharge_ticks_r <= 16'd3;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ANGLE_MIN:       angle_min_r       <= cfg_data[SAMPLE_W-1:0];
        REG_ANGLE_MAX:       angle_max_r       <= cfg_data[SAMPLE_W-1:0];
        REG_BATT_PRESENT:    batt_present_r    <= cfg_data[SAMPLE_W-1:0];
        REG_CHARGE_START:    charge_start_r    <= cfg_data[SAMPLE_W-1:0];
        REG_CHARGE_END:      charge_end_r      <= cfg_data[SAMPLE_W-1:0];
        REG_DELTA_LIMIT:     delta_limit_r     <= cfg_data[SAMPLE_W-1:0];
        REG_CHARGE_TICKS:    charge_ticks_r    <= cfg_data[TIMER_W-1:0];
        REG_DISCHARGE_TICKS: discharge_ticks_r <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_tick_r    <= in_ch.tick;
      s1_voltage_r <= in_ch.voltage;
      s1_current_r <= in_ch.current;
      s1_adjust_r  <= in_ch.adjust;
      s1_adj_chg_r <= in_ch.adjust_changed;
    end
  end

  // Controller state; it changes only when a pass completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_voltage_r <= '0;
      phase_timer_r  <= '0;
      angle_trim_r   <= '0;
      end_hits_r     <= '0;
      run_r          <= 1'b0;
      first_conn_r   <= 1'b0;
      charge_r       <= 1'b0;
      discharge_r    <= 1'b0;
      hold_r         <= 1'b0;
      upd_pend_r     <= 1'b1;
      angle_r        <= '0;
      duty_r         <= '0;
    end else if (advance) begin
      prev_voltage_r <= prev_voltage_nxt;
      phase_timer_r  <= phase_timer_nxt;
      angle_trim_r   <= angle_trim_nxt;
      end_hits_r     <= end_hits_nxt;
      run_r          <= run_nxt;
      first_conn_r   <= first_conn_nxt;
      charge_r       <= charge_nxt;
      discharge_r    <= discharge_nxt;
      hold_r         <= hold_nxt;
      upd_pend_r     <= upd_pend_nxt;
      angle_r        <= angle_nxt;
      duty_r         <= duty_nxt;
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The result fields show the state left by the latest completed pass.
  assign out_ch.valid            = out_valid_r;
  assign out_ch.fire_angle       = angle_r;
  assign out_ch.pwm_duty         = duty_r;
  assign out_ch.charging         = charge_r;
  assign out_ch.discharging      = discharge_r;
  assign out_ch.process_running  = run_r;
  assign out_ch.fast_change_hold = hold_r;

endmodule
